// ----- src/window_average_pass_detector_top_assert.svh -----
// assertion macros for the pass detector
`ifndef WINDOW_AVERAGE_PASS_DETECTOR_TOP_ASSERT_SVH
`define WINDOW_AVERAGE_PASS_DETECTOR_TOP_ASSERT_SVH

// clocked check, masked while reset is held
`define WAPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define WAPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/wapd_pkg.sv -----
package wapd_pkg;

  localparam int unsigned DATA_W              = 16;
  localparam int unsigned MIN_W               = 8;
  localparam int unsigned DEFAULT_WINDOW_SIZE = 40;

  localparam logic [MIN_W-1:0]  MIN_CAP         = 8'd255;
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 16'd150;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TAIL,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } wapd_state_e;

  typedef struct packed {
    logic start;
  } wapd_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wapd_div_stat_t;

endpackage

// ----- src/wapd_window_mem.sv -----
module wapd_window_mem #(
  parameter int unsigned DEPTH = wapd_pkg::DEFAULT_WINDOW_SIZE,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [wapd_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [wapd_pkg::DATA_W-1:0] rdata_o
);

  logic [wapd_pkg::DATA_W-1:0] mem [DEPTH];
  logic [wapd_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/wapd_div.sv -----
module wapd_div #(
  parameter int unsigned DIVIDEND_W = 22,
  parameter int unsigned DIVISOR    = wapd_pkg::DEFAULT_WINDOW_SIZE
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wapd_pkg::wapd_div_ctrl_t ctrl_i,
  input  logic [DIVIDEND_W-1:0]   dividend_i,
  output wapd_pkg::wapd_div_stat_t stat_o,
  output logic [DIVIDEND_W-1:0]   quotient_o
);

  // floor(x / DIVISOR) as (x * ceil(2^SHIFT / DIVISOR)) >> SHIFT, exact for any
  // DIVIDEND_W-bit x since the rounding error stays below 1 / DIVISOR
  localparam int unsigned SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int unsigned RECIP_W = DIVIDEND_W + 1;
  localparam int unsigned PROD_W  = DIVIDEND_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [DIVIDEND_W-1:0] dvd_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  busy_q;
  logic                  done_q;

  // start latches the operand, the next cycle forms the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= ctrl_i.start;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dvd_q <= dividend_i;
    end
    if (busy_q) begin
      prod_q <= PROD_W'(dvd_q) * PROD_W'(RECIP);
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = DIVIDEND_W'(prod_q >> SHIFT);

endmodule

// ----- src/window_average_pass_detector_top.sv -----
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+-----------------------------------
// sample    | in        | in_valid_i / in_stall_o | sample_distance_i[15:0]
// result    | out       | out_valid_o/out_stall_i | window_mean_o[15:0], window_minimum_o[7:0]
// config    | in        | cfg_we_i                | pass_threshold_i[15:0]
//
// a sample that leaves the window short of full is only stored, a full window
// is walked entry by entry from the read port through the shared adder, and
// a pass then runs the reciprocal multiply and loads the output register
// in_stall_o stays high while a transaction is being worked on
// a pending result waits in the output register; a second pass waits for it
// reset clears the fill count and write position, the window memory is not cleared
module window_average_pass_detector_top #(
  parameter int unsigned WINDOW_SIZE = wapd_pkg::DEFAULT_WINDOW_SIZE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wapd_pkg::DATA_W-1:0]  pass_threshold_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [wapd_pkg::DATA_W-1:0]  sample_distance_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wapd_pkg::DATA_W-1:0]  window_mean_o,
  output logic [wapd_pkg::MIN_W-1:0]   window_minimum_o
);

  `include "window_average_pass_detector_top_assert.svh"

  localparam int unsigned AW     = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_SIZE + 1);
  // sum of all entries never exceeds 65535 * WINDOW_SIZE
  localparam int unsigned SUM_W  = wapd_pkg::DATA_W + $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(WINDOW_SIZE - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW_SIZE);

  wapd_pkg::wapd_state_e state_q, state_d;

  logic [wapd_pkg::DATA_W-1:0] thr_q;
  logic [SUM_W-1:0]            prod_q;
  logic [FILL_W-1:0]           fill_q, fill_d, fill_inc;
  logic [AW-1:0]               wr_pos_q, wr_pos_d, wr_pos_inc;
  logic [AW-1:0]               rd_addr_q, rd_addr_d;
  logic                        rd_valid_q;
  logic [SUM_W-1:0]            sum_q, sum_d;
  logic [wapd_pkg::MIN_W-1:0]  min_q, min_d;
  logic                        out_valid_q, out_valid_d;
  logic [wapd_pkg::DATA_W-1:0] mean_q;
  logic [wapd_pkg::MIN_W-1:0]  min_out_q;

  logic                        in_accept;
  logic                        out_free;
  logic                        out_load;
  logic [wapd_pkg::DATA_W-1:0] rd_data;
  logic [SUM_W-1:0]            quotient;

  wapd_pkg::wapd_div_ctrl_t div_ctrl;
  wapd_pkg::wapd_div_stat_t div_stat;

  assign in_stall_o = (state_q != wapd_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // output slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  assign fill_inc   = (fill_q < FULL) ? (fill_q + 1'b1) : fill_q;
  assign wr_pos_inc = (wr_pos_q == LAST_ADDR) ? '0 : (wr_pos_q + 1'b1);

  wapd_window_mem #(
    .DEPTH (WINDOW_SIZE)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wr_pos_q),
    .wdata_i (sample_distance_i),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  wapd_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR    (WINDOW_SIZE)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (sum_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // sequencer: store, walk the window, compare, divide, emit
  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    wr_pos_d       = wr_pos_q;
    rd_addr_d      = rd_addr_q;
    sum_d          = sum_q;
    min_d          = min_q;
    div_ctrl.start = 1'b0;
    out_load       = 1'b0;

    // shared adder and min compare, one entry per cycle from the read port
    if (rd_valid_q) begin
      sum_d = sum_q + SUM_W'(rd_data);
      if (rd_data < wapd_pkg::DATA_W'(min_q)) begin
        min_d = rd_data[wapd_pkg::MIN_W-1:0];
      end
    end

    case (state_q)
      wapd_pkg::ST_IDLE: begin
        if (in_accept) begin
          fill_d   = fill_inc;
          wr_pos_d = wr_pos_inc;
          // window full after this sample: evaluate it
          if (fill_inc == FULL) begin
            state_d   = wapd_pkg::ST_WALK;
            rd_addr_d = '0;
            sum_d     = '0;
            min_d     = wapd_pkg::MIN_CAP;
          end
        end
      end
      wapd_pkg::ST_WALK: begin
        if (rd_addr_q == LAST_ADDR) begin
          state_d = wapd_pkg::ST_TAIL;
        end else begin
          rd_addr_d = rd_addr_q + 1'b1;
        end
      end
      wapd_pkg::ST_TAIL: begin
        // last entry lands in the accumulator this cycle
        state_d = wapd_pkg::ST_CHECK;
      end
      wapd_pkg::ST_CHECK: begin
        // mean at or below threshold, compared as sum <= threshold * N
        if (sum_q <= prod_q) begin
          div_ctrl.start = 1'b1;
          fill_d         = '0;
          wr_pos_d       = '0;
          state_d        = wapd_pkg::ST_DIV;
        end else begin
          state_d = wapd_pkg::ST_IDLE;
        end
      end
      wapd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = wapd_pkg::ST_EMIT;
        end
      end
      wapd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = wapd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wapd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wapd_pkg::ST_IDLE;
      thr_q       <= wapd_pkg::THRESHOLD_RESET;
      fill_q      <= '0;
      wr_pos_q    <= '0;
      rd_addr_q   <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wr_pos_q    <= wr_pos_d;
      rd_addr_q   <= rd_addr_d;
      // a read issued in the walk returns its data in the next cycle
      rd_valid_q  <= (state_q == wapd_pkg::ST_WALK);
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= pass_threshold_i;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    // limit is registered from the threshold and follows it in the next cycle
    prod_q <= SUM_W'(thr_q) * SUM_W'(WINDOW_SIZE);
    sum_q  <= sum_d;
    min_q  <= min_d;
    if (out_load) begin
      mean_q    <= quotient[wapd_pkg::DATA_W-1:0];
      min_out_q <= min_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign window_mean_o    = mean_q;
  assign window_minimum_o = min_out_q;

  // divider only runs for a window that passed the compare
  `WAPD_ASSERT(a_div_after_pass, (state_q == wapd_pkg::ST_DIV) |-> (sum_q <= prod_q), "divide without pass")
  // a fresh result leaves the window emptied
  `WAPD_ASSERT(a_emit_clears, $rose(out_valid_o) |-> (fill_q == '0 && wr_pos_q == '0), "window not cleared")
  // the floored mean can never exceed the threshold it passed
  `WAPD_ASSERT(a_mean_bound, out_load |=> (window_mean_o <= thr_q), "mean above threshold")
  // no transaction is taken while the sequencer is busy, even in reset
  `WAPD_ASSERT_ALWAYS(a_idle_accept, in_accept |-> (state_q == wapd_pkg::ST_IDLE && !div_stat.busy), "accept while busy")

endmodule
